@@ sv/hdop_pkg.sv @@
// ----------------------------------------------------------------------------
// hdop_pkg
// Shared constants for the Hamming-distance-one pair finder: default sizes,
// field widths and the codes carried on the request and response channels.
// ----------------------------------------------------------------------------
package hdop_pkg;

   // Default sizing of the word store.
   localparam int MAX_WORDS_DEF = 64;
   localparam int WORD_BITS_DEF = 32;

   // Fixed widths of the channel fields.
   localparam int REQ_WORD_W  = 32;
   localparam int RSP_INDEX_W = 6;
   localparam int RSP_WORD_W  = 32;
   localparam int RSP_TOTAL_W = 11;
   localparam int STATUS_W    = 2;

   // Request kinds.
   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // Closing status codes.
   localparam logic [STATUS_W-1:0] STAT_STORED    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_CLEARED   = 2'd3;

   // The running pair total saturates here.
   localparam logic [RSP_TOTAL_W-1:0] TOTAL_MAX = 11'd2047;

   // Most pair responses given for one request; the rest are only counted.
   localparam logic [5:0] PAIR_RSP_LIMIT = 6'd63;

endpackage

@@ sv/hamming_distance_one_pair_finder.sv @@
// ----------------------------------------------------------------------------
// hamming_distance_one_pair_finder
// Keeps a set of distinct words and reports every stored word that differs
// from a newly added word in exactly one bit.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_valid, req_stall, req_kind, req_word): an add
//   request carries a word, a clear request empties the store and zeroes the
//   running pair total. Only the low WORD_BITS bits of req_word are used.
//   Response channel (rsp_valid, rsp_stall, rsp_*): an add produces one pair
//   response per one-bit neighbour, in store order, then one closing status
//   response with rsp_last high. Duplicate, full and clear requests give the
//   status response alone.
//   The words live in a single-port-write, registered-read memory. An add
//   makes two scans over the N stored words, one read per cycle unless a
//   stalled response holds the second: the first looks for an equal word,
//   the second for one-bit neighbours. A full store skips the second scan,
//   and every response that waits on rsp_stall delays the request further.
//   One request is handled at a time; req_stall is high while one is busy.
//   A stalled response holds the neighbour scan at the matching entry until
//   the transfer completes, so nothing is lost.
//   Reset empties the store (the count returns to zero, no clearing pass is
//   needed) and zeroes the pair total.
// ----------------------------------------------------------------------------
module hamming_distance_one_pair_finder #(
   parameter int MAX_WORDS = hdop_pkg::MAX_WORDS_DEF,
   parameter int WORD_BITS = hdop_pkg::WORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [hdop_pkg::REQ_WORD_W-1:0]      req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_is_pair,
   output logic [hdop_pkg::RSP_INDEX_W-1:0]     rsp_earlier_index,
   output logic [hdop_pkg::RSP_INDEX_W-1:0]     rsp_new_index,
   output logic [hdop_pkg::RSP_WORD_W-1:0]      rsp_earlier_word,
   output logic [hdop_pkg::STATUS_W-1:0]        rsp_status,
   output logic [hdop_pkg::RSP_TOTAL_W-1:0]     rsp_pair_total,
   output logic                                 rsp_last
);

   localparam int IDX_W = $clog2(MAX_WORDS);
   localparam int CNT_W = $clog2(MAX_WORDS + 1);
   localparam int XW    = hdop_pkg::RSP_INDEX_W;
   localparam int TW    = hdop_pkg::RSP_TOTAL_W;

   // Controller states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DUP  = 2'd1;
   localparam logic [1:0] ST_PAIR = 2'd2;
   localparam logic [1:0] ST_STAT = 2'd3;

   // Control and working registers.
   logic [1:0]                    state_ff, state_in;
   logic [WORD_BITS-1:0]          word_ff, word_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [TW-1:0]                 pairs_ff, pairs_in;
   logic [CNT_W-1:0]              rd_idx_ff, rd_idx_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]              chk_idx_ff, chk_idx_in;
   logic [5:0]                    emit_cnt_ff, emit_cnt_in;
   logic [hdop_pkg::STATUS_W-1:0] stat_code_ff, stat_code_in;
   logic [IDX_W-1:0]              stat_idx_ff, stat_idx_in;

   // Response register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_is_pair_ff, rsp_is_pair_in;
   logic [XW-1:0]                 rsp_earlier_index_ff, rsp_earlier_index_in;
   logic [XW-1:0]                 rsp_new_index_ff, rsp_new_index_in;
   logic [hdop_pkg::RSP_WORD_W-1:0] rsp_earlier_word_ff, rsp_earlier_word_in;
   logic [hdop_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [TW-1:0]                 rsp_pair_total_ff, rsp_pair_total_in;
   logic                          rsp_last_ff, rsp_last_in;

   // Word store and its registered read port.
   logic [WORD_BITS-1:0]          store_mem [MAX_WORDS];
   logic [WORD_BITS-1:0]          rd_data_ff;
   logic                          mem_rd_en;
   logic                          mem_we;

   // Helper values.
   logic [WORD_BITS+hdop_pkg::REQ_WORD_W-1:0] req_word_ext;
   logic [WORD_BITS+hdop_pkg::RSP_WORD_W-1:0] rd_word_ext;
   logic [IDX_W+XW-1:0]           chk_idx_ext;
   logic [IDX_W+XW-1:0]           stat_idx_ext;
   logic [IDX_W+XW-1:0]           count_idx_ext;
   logic [WORD_BITS-1:0]          diff;
   logic [WORD_BITS-1:0]          diff_m1;
   logic                          one_bit;
   logic                          dup_hit;
   logic                          pair_hit;
   logic                          need_rsp;
   logic                          rsp_free;
   logic                          scan_done;
   logic [TW-1:0]                 pairs_inc;

   assign req_word_ext  = {{WORD_BITS{1'b0}}, req_word};
   assign rd_word_ext   = {{hdop_pkg::RSP_WORD_W{1'b0}}, rd_data_ff};
   assign chk_idx_ext   = {{XW{1'b0}}, chk_idx_ff};
   assign stat_idx_ext  = {{XW{1'b0}}, stat_idx_ff};
   assign count_idx_ext = {{XW{1'b0}}, count_ff[IDX_W-1:0]};

   // Compare of the entry just read with the word being added.
   assign diff     = rd_data_ff ^ word_ff;
   assign diff_m1  = diff - WORD_BITS'(1);
   assign one_bit  = (diff != '0) && ((diff & diff_m1) == '0);
   assign dup_hit  = chk_vld_ff && (rd_data_ff == word_ff);
   assign pair_hit = chk_vld_ff && one_bit;
   assign need_rsp = pair_hit && (emit_cnt_ff < hdop_pkg::PAIR_RSP_LIMIT);

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_done = !chk_vld_ff && (rd_idx_ff == count_ff);
   assign pairs_inc = (pairs_ff == hdop_pkg::TOTAL_MAX) ? pairs_ff : pairs_ff + TW'(1);

   assign req_stall = (state_ff != ST_IDLE);

   // Next-state logic of the controller, the scans and the response register.
   always_comb begin
      state_in             = state_ff;
      word_in              = word_ff;
      count_in             = count_ff;
      pairs_in             = pairs_ff;
      rd_idx_in            = rd_idx_ff;
      chk_vld_in           = chk_vld_ff;
      chk_idx_in           = chk_idx_ff;
      emit_cnt_in          = emit_cnt_ff;
      stat_code_in         = stat_code_ff;
      stat_idx_in          = stat_idx_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_is_pair_in       = rsp_is_pair_ff;
      rsp_earlier_index_in = rsp_earlier_index_ff;
      rsp_new_index_in     = rsp_new_index_ff;
      rsp_earlier_word_in  = rsp_earlier_word_ff;
      rsp_status_in        = rsp_status_ff;
      rsp_pair_total_in    = rsp_pair_total_ff;
      rsp_last_in          = rsp_last_ff;
      mem_rd_en            = 1'b0;
      mem_we               = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == hdop_pkg::KIND_CLEAR) begin
                  count_in     = '0;
                  pairs_in     = '0;
                  stat_code_in = hdop_pkg::STAT_CLEARED;
                  stat_idx_in  = '0;
                  state_in     = ST_STAT;
               end else begin
                  word_in    = req_word_ext[WORD_BITS-1:0];
                  rd_idx_in  = '0;
                  chk_vld_in = 1'b0;
                  state_in   = ST_DUP;
               end
            end
         end

         // First scan: look for a stored word equal to the new one.
         ST_DUP: begin
            if (dup_hit) begin
               stat_code_in = hdop_pkg::STAT_DUPLICATE;
               stat_idx_in  = chk_idx_ff;
               state_in     = ST_STAT;
            end else if (scan_done) begin
               if (count_ff == CNT_W'(MAX_WORDS)) begin
                  stat_code_in = hdop_pkg::STAT_FULL;
                  stat_idx_in  = '0;
                  state_in     = ST_STAT;
               end else begin
                  rd_idx_in   = '0;
                  chk_vld_in  = 1'b0;
                  emit_cnt_in = '0;
                  state_in    = ST_PAIR;
               end
            end else if (rd_idx_ff < count_ff) begin
               mem_rd_en  = 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = rd_idx_ff[IDX_W-1:0];
               rd_idx_in  = rd_idx_ff + CNT_W'(1);
            end else begin
               chk_vld_in = 1'b0;
            end
         end

         // Second scan: report one-bit neighbours; a stalled response holds it.
         ST_PAIR: begin
            if (!(need_rsp && !rsp_free)) begin
               if (pair_hit) begin
                  pairs_in = pairs_inc;
               end
               if (need_rsp) begin
                  rsp_valid_in         = 1'b1;
                  rsp_is_pair_in       = 1'b1;
                  rsp_earlier_index_in = chk_idx_ext[XW-1:0];
                  rsp_new_index_in     = count_idx_ext[XW-1:0];
                  rsp_earlier_word_in  = rd_word_ext[hdop_pkg::RSP_WORD_W-1:0];
                  rsp_status_in        = hdop_pkg::STAT_STORED;
                  rsp_pair_total_in    = pairs_inc;
                  rsp_last_in          = 1'b0;
                  emit_cnt_in          = emit_cnt_ff + 6'd1;
               end
               if (scan_done) begin
                  mem_we       = 1'b1;
                  count_in     = count_ff + CNT_W'(1);
                  stat_code_in = hdop_pkg::STAT_STORED;
                  stat_idx_in  = count_ff[IDX_W-1:0];
                  state_in     = ST_STAT;
               end else if (rd_idx_ff < count_ff) begin
                  mem_rd_en  = 1'b1;
                  chk_vld_in = 1'b1;
                  chk_idx_in = rd_idx_ff[IDX_W-1:0];
                  rd_idx_in  = rd_idx_ff + CNT_W'(1);
               end else begin
                  chk_vld_in = 1'b0;
               end
            end
         end

         // Closing status response.
         ST_STAT: begin
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_is_pair_in       = 1'b0;
               rsp_earlier_index_in = '0;
               rsp_new_index_in     = stat_idx_ext[XW-1:0];
               rsp_earlier_word_in  = '0;
               rsp_status_in        = stat_code_ff;
               rsp_pair_total_in    = pairs_ff;
               rsp_last_in          = 1'b1;
               state_in             = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pairs_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pairs_ff     <= pairs_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      word_ff              <= word_in;
      rd_idx_ff            <= rd_idx_in;
      chk_idx_ff           <= chk_idx_in;
      emit_cnt_ff          <= emit_cnt_in;
      stat_code_ff         <= stat_code_in;
      stat_idx_ff          <= stat_idx_in;
      rsp_is_pair_ff       <= rsp_is_pair_in;
      rsp_earlier_index_ff <= rsp_earlier_index_in;
      rsp_new_index_ff     <= rsp_new_index_in;
      rsp_earlier_word_ff  <= rsp_earlier_word_in;
      rsp_status_ff        <= rsp_status_in;
      rsp_pair_total_ff    <= rsp_pair_total_in;
      rsp_last_ff          <= rsp_last_in;
   end

   // Word store: one write port at the fill count, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[count_ff[IDX_W-1:0]] <= word_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_data_ff <= store_mem[rd_idx_ff[IDX_W-1:0]];
      end
   end

   // Response ports.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_pair       = rsp_is_pair_ff;
   assign rsp_earlier_index = rsp_earlier_index_ff;
   assign rsp_new_index     = rsp_new_index_ff;
   assign rsp_earlier_word  = rsp_earlier_word_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_pair_total    = rsp_pair_total_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

@@ tb/pair_finder_checker.sv @@
// ----------------------------------------------------------------------------
// pair_finder_checker
// Watches the request and response channels of the pair finder. It keeps
// its own copy of the word store and the running pair total, works out the
// responses that each accepted request should give, and compares every
// accepted response field by field with the oldest one still awaited.
// ----------------------------------------------------------------------------
module pair_finder_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [hdop_pkg::REQ_WORD_W-1:0]      req_word,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic                                 rsp_is_pair,
   input  logic [hdop_pkg::RSP_INDEX_W-1:0]     rsp_earlier_index,
   input  logic [hdop_pkg::RSP_INDEX_W-1:0]     rsp_new_index,
   input  logic [hdop_pkg::RSP_WORD_W-1:0]      rsp_earlier_word,
   input  logic [hdop_pkg::STATUS_W-1:0]        rsp_status,
   input  logic [hdop_pkg::RSP_TOTAL_W-1:0]     rsp_pair_total,
   input  logic                                 rsp_last,
   output int                                   fail_count,
   output int                                   pending_count
);

   localparam int RW = hdop_pkg::REQ_WORD_W;
   localparam int XW = hdop_pkg::RSP_INDEX_W;
   localparam int WW = hdop_pkg::RSP_WORD_W;
   localparam int SW = hdop_pkg::STATUS_W;
   localparam int TW = hdop_pkg::RSP_TOTAL_W;

   // Only the low WORD_BITS bits of a request word take part.
   localparam logic [63:0]   WORD_MASK_WIDE = (64'd1 << hdop_pkg::WORD_BITS_DEF) - 64'd1;
   localparam logic [RW-1:0] WORD_MASK      = WORD_MASK_WIDE[RW-1:0];

   typedef struct packed {
      logic          is_pair;
      logic [XW-1:0] earlier_index;
      logic [XW-1:0] new_index;
      logic [WW-1:0] earlier_word;
      logic [SW-1:0] status;
      logic [TW-1:0] pair_total;
      logic          last;
   } pair_response_type;

   // Shadow copy of the block's state.
   logic [WW-1:0] word_store [hdop_pkg::MAX_WORDS_DEF];
   int            stored_count;
   logic [TW-1:0] pairs_found;

   // Responses still owed by the block, oldest first.
   pair_response_type awaited_responses [$];
   pair_response_type oldest;

   function automatic pair_response_type make_response(
      input logic          is_pair,
      input logic [XW-1:0] earlier_index,
      input logic [XW-1:0] new_index,
      input logic [WW-1:0] earlier_word,
      input logic [SW-1:0] status,
      input logic [TW-1:0] pair_total,
      input logic          last
   );
      pair_response_type r;
      r.is_pair       = is_pair;
      r.earlier_index = earlier_index;
      r.new_index     = new_index;
      r.earlier_word  = earlier_word;
      r.status        = status;
      r.pair_total    = pair_total;
      r.last          = last;
      return r;
   endfunction

   // Update the shadow store for one request and queue the responses it owes.
   task automatic predict_pair_responses(input logic kind,
                                         input logic [RW-1:0] word);
      logic [WW-1:0] w;
      logic [WW-1:0] diff;
      int            slot;
      int            emitted;
      w = word & WORD_MASK;

      // A clear empties the store and zeroes the total.
      if (kind == hdop_pkg::KIND_CLEAR) begin
         stored_count = 0;
         pairs_found  = '0;
         awaited_responses.push_back(make_response(1'b0, '0, '0, '0,
                                                   hdop_pkg::STAT_CLEARED, '0, 1'b1));
         return;
      end

      // An equal word is a duplicate, even when the store is full.
      for (int i = 0; i < stored_count; i++) begin
         if (word_store[i] == w) begin
            awaited_responses.push_back(make_response(1'b0, '0, i[XW-1:0], '0,
                                                      hdop_pkg::STAT_DUPLICATE,
                                                      pairs_found, 1'b1));
            return;
         end
      end

      if (stored_count >= hdop_pkg::MAX_WORDS_DEF) begin
         awaited_responses.push_back(make_response(1'b0, '0, '0, '0, hdop_pkg::STAT_FULL,
                                                   pairs_found, 1'b1));
         return;
      end

      // Every stored word one bit away is a pair; the total saturates and the
      // number of pair responses per request is capped.
      slot    = stored_count;
      emitted = 0;
      for (int i = 0; i < slot; i++) begin
         diff = word_store[i] ^ w;
         if (diff != '0 && (diff & (diff - WW'(1))) == '0) begin
            if (pairs_found < hdop_pkg::TOTAL_MAX) pairs_found = pairs_found + TW'(1);
            if (emitted < int'(hdop_pkg::PAIR_RSP_LIMIT)) begin
               awaited_responses.push_back(make_response(1'b1, i[XW-1:0], slot[XW-1:0],
                                                         word_store[i],
                                                         hdop_pkg::STAT_STORED,
                                                         pairs_found, 1'b0));
               emitted++;
            end
         end
      end
      word_store[slot] = w;
      stored_count     = slot + 1;
      awaited_responses.push_back(make_response(1'b0, '0, slot[XW-1:0], '0,
                                                hdop_pkg::STAT_STORED, pairs_found, 1'b1));
   endtask

   task automatic check_field(input string field, input logic [31:0] expected_value,
                              input logic [31:0] actual_value);
      if (expected_value !== actual_value) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h",
                  $time, field, expected_value, actual_value);
         fail_count++;
      end
   endtask

   // Compare response transfers first, then take in any request transfer.
   always @(posedge clock) begin
      if (reset) begin
         stored_count = 0;
         pairs_found  = '0;
         fail_count   = 0;
         awaited_responses.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               $display("%0t: response transfer with none awaited, expected none, actual %0h",
                        $time, {rsp_is_pair, rsp_earlier_index, rsp_new_index,
                                rsp_earlier_word, rsp_status, rsp_pair_total, rsp_last});
               fail_count++;
            end else begin
               oldest = awaited_responses.pop_front();
               check_field("is_pair", oldest.is_pair, rsp_is_pair);
               check_field("earlier_index", oldest.earlier_index, rsp_earlier_index);
               check_field("new_index", oldest.new_index, rsp_new_index);
               check_field("earlier_word", oldest.earlier_word, rsp_earlier_word);
               check_field("status", oldest.status, rsp_status);
               check_field("pair_total", oldest.pair_total, rsp_pair_total);
               check_field("last", oldest.last, rsp_last);
            end
         end
         if (req_valid && !req_stall) predict_pair_responses(req_kind, req_word);
      end
      pending_count = awaited_responses.size();
   end

endmodule

@@ tb/hamming_distance_one_pair_finder_tb.sv @@
// ----------------------------------------------------------------------------
// hamming_distance_one_pair_finder_tb
// Drives the pair finder with a short directed set of words followed by
// random sequences: neighbourhoods of a centre word, fills of the whole store
// with a six-bit subcube, and loose noise. Both sides idle at random in the
// first two of three phases; the checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module hamming_distance_one_pair_finder_tb;

   localparam int ITEM_TARGET = 500;
   localparam int LIMIT_TIME  = 20_000_000;
   localparam int RW          = hdop_pkg::REQ_WORD_W;

   logic                                 clock     = 1'b0;
   logic                                 reset     = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic                                 req_kind  = hdop_pkg::KIND_ADD;
   logic [RW-1:0]                        req_word  = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic                                 rsp_is_pair;
   logic [hdop_pkg::RSP_INDEX_W-1:0]     rsp_earlier_index;
   logic [hdop_pkg::RSP_INDEX_W-1:0]     rsp_new_index;
   logic [hdop_pkg::RSP_WORD_W-1:0]      rsp_earlier_word;
   logic [hdop_pkg::STATUS_W-1:0]        rsp_status;
   logic [hdop_pkg::RSP_TOTAL_W-1:0]     rsp_pair_total;
   logic                                 rsp_last;

   int fail_count;
   int pending_count;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int items_sent   = 0;

   // Words added since the last clear, used to aim at duplicates and pairs.
   logic [RW-1:0] sent_words [$];

   hamming_distance_one_pair_finder u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_word          (req_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_is_pair       (rsp_is_pair),
      .rsp_earlier_index (rsp_earlier_index),
      .rsp_new_index     (rsp_new_index),
      .rsp_earlier_word  (rsp_earlier_word),
      .rsp_status        (rsp_status),
      .rsp_pair_total    (rsp_pair_total),
      .rsp_last          (rsp_last)
   );

   pair_finder_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_word          (req_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_is_pair       (rsp_is_pair),
      .rsp_earlier_index (rsp_earlier_index),
      .rsp_new_index     (rsp_new_index),
      .rsp_earlier_word  (rsp_earlier_word),
      .rsp_status        (rsp_status),
      .rsp_pair_total    (rsp_pair_total),
      .rsp_last          (rsp_last),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   always #5 clock = ~clock;

   // The response side stalls at random, decided at each falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // Run ends here if the block stops making progress.
   initial begin
      #LIMIT_TIME;
      $display("hamming_distance_one_pair_finder verification failed");
      $finish;
   end

   // One request transfer, with random idle cycles ahead of it. Entered and
   // left at a falling edge.
   task automatic send_request(input logic kind, input logic [RW-1:0] word);
      if (items_sent < ITEM_TARGET / 3) begin
         req_idle_pct = 34;
         rsp_idle_pct = 60;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
         req_idle_pct = 60;
         rsp_idle_pct = 34;
      end else begin
         req_idle_pct = 0;
         rsp_idle_pct = 0;
      end
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_word  <= word;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
      if (kind == hdop_pkg::KIND_CLEAR) sent_words.delete();
      else sent_words.push_back(word);
   endtask

   function automatic logic [RW-1:0] pick_sent_word();
      if (sent_words.size() == 0) return $urandom();
      return sent_words[$urandom_range(sent_words.size() - 1)];
   endfunction

   // Hold the request side until every owed response has been transferred.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   // One-bit neighbours of a centre word, then the centre itself, the centre again and a two-bit neighbour.
   task automatic run_neighbourhood();
      logic [RW-1:0] centre;
      int            n_flips;
      int            k;
      centre = $urandom();
      if ($urandom_range(3) != 0) send_request(hdop_pkg::KIND_CLEAR, $urandom());
      if ($urandom_range(3) == 0) begin
         // All 32 neighbours, so the centre meets its largest pair count.
         for (k = 0; k < 32; k++) send_request(hdop_pkg::KIND_ADD, centre ^ (32'd1 << k));
      end else begin
         n_flips = $urandom_range(1, 16);
         for (k = 0; k < n_flips; k++)
            send_request(hdop_pkg::KIND_ADD, centre ^ (32'd1 << $urandom_range(31)));
      end
      send_request(hdop_pkg::KIND_ADD, centre);
      send_request(hdop_pkg::KIND_ADD, centre);
      send_request(hdop_pkg::KIND_ADD, centre ^ (32'd3 << $urandom_range(30)));
   endtask

   // Fill the store with a six-bit subcube around a base word, then knock on the full
   // store with a fresh word, with a stored one and with a one-bit change of the base word.
   task automatic run_fill();
      logic [RW-1:0] base_word;
      logic [RW-1:0] spread;
      int            start_bit;
      int            stride;
      int            offset;
      int            j;
      int            b;
      base_word = $urandom();
      start_bit = $urandom_range(31);
      stride    = 2 * $urandom_range(15) + 1;
      offset    = $urandom_range(63);
      send_request(hdop_pkg::KIND_CLEAR, $urandom());
      for (j = 0; j < hdop_pkg::MAX_WORDS_DEF; j++) begin
         spread = '0;
         for (b = 0; b < 6; b++)
            if (((j ^ offset) >> b) & 1) spread[(start_bit + b * stride) % 32] = 1'b1;
         send_request(hdop_pkg::KIND_ADD, base_word ^ spread);
         if ($urandom_range(15) == 0) send_request(hdop_pkg::KIND_ADD, pick_sent_word());
      end
      send_request(hdop_pkg::KIND_ADD, $urandom());
      send_request(hdop_pkg::KIND_ADD, pick_sent_word());
      send_request(hdop_pkg::KIND_ADD, base_word ^ (32'd1 << $urandom_range(31)));
   endtask

   // Loose mix of clears, extremes, fresh words, copies and near copies.
   task automatic run_noise();
      int n;
      int k;
      n = $urandom_range(1, 10);
      for (k = 0; k < n; k++) begin
         case ($urandom_range(7))
            0: send_request(hdop_pkg::KIND_CLEAR, $urandom());
            1: send_request(hdop_pkg::KIND_ADD,
                            $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000);
            2, 3: send_request(hdop_pkg::KIND_ADD,
                               pick_sent_word() ^ (32'd1 << $urandom_range(31)));
            4: send_request(hdop_pkg::KIND_ADD, pick_sent_word());
            default: send_request(hdop_pkg::KIND_ADD, $urandom());
         endcase
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes, pairs at both ends of the word, duplicates, and a
      // clear that carries a word which must be ignored.
      send_request(hdop_pkg::KIND_CLEAR, 32'h0000_0000);
      send_request(hdop_pkg::KIND_ADD,   32'h0000_0000);
      send_request(hdop_pkg::KIND_ADD,   32'h0000_0000);
      send_request(hdop_pkg::KIND_ADD,   32'h0000_0001);
      send_request(hdop_pkg::KIND_ADD,   32'h8000_0000);
      send_request(hdop_pkg::KIND_ADD,   32'hFFFF_FFFF);
      send_request(hdop_pkg::KIND_ADD,   32'h7FFF_FFFF);
      send_request(hdop_pkg::KIND_ADD,   32'hFFFF_FFFE);
      send_request(hdop_pkg::KIND_ADD,   32'h0000_0003);
      send_request(hdop_pkg::KIND_ADD,   32'h8000_0000);
      send_request(hdop_pkg::KIND_CLEAR, 32'hFFFF_FFFF);
      send_request(hdop_pkg::KIND_ADD,   32'hFFFF_FFFF);
      send_request(hdop_pkg::KIND_ADD,   32'hFFFF_FFFF);
      send_request(hdop_pkg::KIND_CLEAR, 32'h5A5A_A5A5);
      drain_responses();

      // Random sequences; the first one fills the store.
      run_fill();
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(9))
            0: run_fill();
            1, 2: run_noise();
            default: run_neighbourhood();
         endcase
      end
      drain_responses();
      repeat (200) @(negedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("hamming_distance_one_pair_finder verification clean");
      end else begin
         $display("hamming_distance_one_pair_finder verification failed");
      end
      $finish;
   end

endmodule
